// File: hw/rtl/positional_char_list_defines.svh
// ---------------------------------------------------------------------------
// Positional character list: assertion macros
// Shared concurrent assertion forms for the list checker.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_CHAR_LIST_DEFINES_SVH
`define POSITIONAL_CHAR_LIST_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define PLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/plc_pkg.sv
// ---------------------------------------------------------------------------
// Positional character list: package
// Operation and status codes, cell commands and the beat types.
// ---------------------------------------------------------------------------
package plc_pkg;

  // Default number of entries in the list.
  localparam int unsigned DefCapacity = 16;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_POP    = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [7:0] value;
  } plc_ctrl_t;

  // Request beat.
  typedef struct packed {
    op_e        op;
    logic [4:0] position;
    logic [7:0] value;
  } plc_req_t;

  // Result beat.
  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic [4:0] found_position;
    logic [4:0] count;
  } plc_rsp_t;

endpackage

// File: hw/rtl/positional_char_list.sv
// ---------------------------------------------------------------------------
// Positional character list: top level
// Ordered list of byte entries with append, insert, delete, pop, read and find.
// ---------------------------------------------------------------------------
// Usage:
//   A request beat (req_i) is taken at a rising edge where start_i is high
//   and busy_o is low. busy_o stays low: a new request may follow every
//   cycle, so the block sustains one operation per clock.
//   Each request yields exactly one result beat on rsp_o, marked by done_o
//   for the single cycle right after the request edge.
//   The receiver cannot stall; the result is replaced by the next one.
//   Storage is a chain of CAPACITY cells; insert and delete move every
//   entry from the addressed position on one cell along the chain in the
//   same cycle, while reads and finds are answered from the cells' read
//   and match outputs. The find search and the read select span the whole
//   chain as a priority encoder and a select tree.
//   Reset empties the list at once; no clearing pass is needed because
//   only entries below the count are ever read.
// ---------------------------------------------------------------------------
module positional_char_list #(
  parameter int unsigned CAPACITY = plc_pkg::DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  plc_pkg::plc_req_t  req_i,
  output logic               done_o,
  output plc_pkg::plc_rsp_t  rsp_o
);
  import plc_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  plc_rsp_t        rsp_q, rsp_d;

  plc_ctrl_t       ctrl;
  logic [IdxW-1:0] idx;
  logic            accept;

  logic [7:0]      entry_w [CAPACITY];
  logic [7:0]      rd_w    [CAPACITY];
  logic [CAPACITY-1:0] match_w;

  logic [7:0]      rd_data;
  logic            any_match;
  logic [IdxW-1:0] first_idx;

  logic [4:0]      pos_eff;
  logic [CmpW-1:0] k_wide;
  logic [IdxW-1:0] k_idx;
  logic            empty, full, in_range;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  // Chain of cells, each handing its entry to both neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = entry_w[g];
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    plc_cell #(
      .IdxW  (IdxW),
      .CntW  (CntW),
      .Index (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (idx),
      .cnt_i   (cnt_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .rd_o    (rd_w[g]),
      .match_o (match_w[g])
    );
  end

  // Read select: only the addressed cell drives a nonzero byte.
  always_comb begin
    rd_data = 8'd0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | rd_w[i];
    end
  end

  // First matching cell for find.
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_w[i]) first_idx = IdxW'(i);
    end
  end
  assign any_match = |match_w;

  // Position decode; position zero is read as position one.
  assign pos_eff  = (req_i.position == 5'd0) ? 5'd1 : req_i.position;
  assign k_wide   = CmpW'(pos_eff) - CmpW'(1);
  assign k_idx    = k_wide[IdxW-1:0];
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CapCnt);
  assign in_range = (CmpW'(pos_eff) <= CmpW'(cnt_q));

  // Operation decode: cell command, new count and the result beat.
  always_comb begin
    logic [CmpW-1:0] fpos;
    logic [CmpW-1:0] cnt_wide;
    ctrl.act   = ACT_HOLD;
    ctrl.value = req_i.value;
    idx        = k_idx;
    cnt_d      = cnt_q;
    rsp_d.status         = ST_OK;
    rsp_d.data           = 8'd0;
    rsp_d.found_position = 5'd0;
    fpos = CmpW'(first_idx) + CmpW'(1);
    case (req_i.op)
      OP_APPEND: begin
        idx = cnt_q[IdxW-1:0];
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          ctrl.act = ACT_LOAD;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      OP_INSERT: begin
        if (empty) begin
          idx      = '0;
          ctrl.act = ACT_INSERT;
          cnt_d    = CntW'(1);
        end else if (!in_range) begin
          rsp_d.status = ST_RANGE;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          ctrl.act = ACT_INSERT;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (!in_range) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.data = rd_data;
          ctrl.act   = ACT_REMOVE;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      OP_POP: begin
        idx = '0;
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.data = rd_data;
          ctrl.act   = ACT_REMOVE;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      OP_READ: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (!in_range) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.data = rd_data;
        end
      end
      OP_FIND: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (any_match) begin
          rsp_d.found_position = fpos[4:0];
        end else begin
          rsp_d.status = ST_NOTFOUND;
        end
      end
      default: begin
        ctrl.act = ACT_HOLD;
      end
    endcase
    if (!accept) begin
      ctrl.act = ACT_HOLD;
      cnt_d    = cnt_q;
    end
    cnt_wide    = CmpW'(cnt_d);
    rsp_d.count = cnt_wide[4:0];
  end

  // Count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  // Result beat register.
  always_ff @(posedge clk_i) begin
    if (accept) rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: hw/rtl/plc_cell.sv
// ---------------------------------------------------------------------------
// Positional character list: storage cell
// Holds one entry, takes a new byte or a neighbor's byte on command, and
// reports its byte for reads and a match flag for searches.
// ---------------------------------------------------------------------------
module plc_cell #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned CntW  = 5,
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  plc_pkg::plc_ctrl_t  ctrl_i,
  input  logic [IdxW-1:0]     idx_i,
  input  logic [CntW-1:0]     cnt_i,
  input  logic [7:0]          left_i,
  input  logic [7:0]          right_i,
  output logic [7:0]          entry_o,
  output logic [7:0]          rd_o,
  output logic                match_o
);
  import plc_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);
  localparam logic [CntW-1:0] MyCnt = CntW'(Index);

  logic [7:0] entry_q, entry_d;

  // Next entry: hold, load the new byte, or take a neighbor's byte.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.act)
      ACT_HOLD: begin
        entry_d = entry_q;
      end
      ACT_LOAD: begin
        if (idx_i == MyIdx) entry_d = ctrl_i.value;
      end
      ACT_INSERT: begin
        if (idx_i == MyIdx) begin
          entry_d = ctrl_i.value;
        end else if (MyIdx > idx_i) begin
          entry_d = left_i;
        end
      end
      ACT_REMOVE: begin
        if (MyIdx >= idx_i) entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Entry storage needs no reset: entries beyond the count are never read.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = (idx_i == MyIdx) ? entry_q : 8'd0;
  assign match_o = (MyCnt < cnt_i) && (entry_q == ctrl_i.value);

endmodule

// File: hw/rtl/plc_chk.sv
// ---------------------------------------------------------------------------
// Positional character list: port checker
// Watches the top-level ports for request/result timing and status sanity.
// ---------------------------------------------------------------------------
`include "positional_char_list_defines.svh"

module plc_chk #(
  parameter int unsigned CAPACITY = plc_pkg::DefCapacity
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input plc_pkg::plc_rsp_t  rsp_o
);
  import plc_pkg::*;

  localparam int unsigned CapW = $clog2(CAPACITY + 1) + 5;
  localparam logic [CapW-1:0] CapVal = CapW'(CAPACITY);
  localparam logic [4:0] CapCount = CapVal[4:0];

  // Every accepted request gives one result beat in the next cycle.
  `PLC_ASSERT(a_done_follows, (start_i && !busy_o) |=> done_o, "missing result beat")
  // No result beat without a request.
  `PLC_ASSERT(a_no_spurious, !(start_i && !busy_o) |=> !done_o, "unrequested result beat")
  // A failed operation returns no data.
  `PLC_ASSERT(a_fail_no_data, (done_o && rsp_o.status != ST_OK) |-> (rsp_o.data == 8'd0),
    "data on failed operation")
  // A full status reports a full list, an empty status an empty one.
  `PLC_ASSERT(a_count_status, (done_o && rsp_o.status == ST_FULL) |-> (rsp_o.count == CapCount),
    "full status with wrong count")
  `PLC_ASSERT(a_empty_count, (done_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.count == 5'd0),
    "empty status with nonzero count")

endmodule

bind positional_char_list plc_chk #(.CAPACITY(CAPACITY)) u_plc_chk (.*);

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// Positional character list: block-level testbench
// Drives request beats through the start/busy handshake with random gaps and
// checks every result beat, field by field, against an in-line list model.
// The model is kept in a small scoreboard class. Plain tasks drive a short
// directed sequence of corner cases, then phases of list growth and shrink.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plc_pkg::*;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int unsigned NumRandom  = 1500;
  localparam int unsigned StallLimit = 200;
  localparam int unsigned DrainLimit = 100;

  // Scoreboard: mirrors the list contents and queues one expected result per request.
  class char_list_scoreboard;
    logic [7:0]  entries [Capacity];
    int unsigned count;
    plc_rsp_t    expected_q [$];
    int unsigned mismatches;

    // Closes the gap left by a removed entry and shortens the list.
    function void remove_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < count; i++) begin
        entries[i] = entries[i + 1];
      end
      count--;
    endfunction

    // Applies one accepted request to the model and queues its result.
    function void note_request(plc_req_t req);
      plc_rsp_t    rsp;
      int unsigned pos;
      rsp        = '0;
      rsp.status = ST_OK;
      pos        = (req.position == 5'd0) ? 1 : req.position;
      case (req.op)
        OP_APPEND: begin
          if (count >= Capacity) begin
            rsp.status = ST_FULL;
          end else begin
            entries[count] = req.value;
            count++;
          end
        end
        OP_INSERT: begin
          if (count == 0) begin
            entries[0] = req.value;
            count      = 1;
          end else if (pos > count) begin
            rsp.status = ST_RANGE;
          end else if (count >= Capacity) begin
            rsp.status = ST_FULL;
          end else begin
            for (int unsigned i = count; i >= pos; i--) begin
              entries[i] = entries[i - 1];
            end
            entries[pos - 1] = req.value;
            count++;
          end
        end
        OP_DELETE: begin
          if (count == 0) begin
            rsp.status = ST_EMPTY;
          end else if (pos > count) begin
            rsp.status = ST_RANGE;
          end else begin
            rsp.data = entries[pos - 1];
            remove_entry(pos - 1);
          end
        end
        OP_POP: begin
          if (count == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.data = entries[0];
            remove_entry(0);
          end
        end
        OP_READ: begin
          if (count == 0) begin
            rsp.status = ST_EMPTY;
          end else if (pos > count) begin
            rsp.status = ST_RANGE;
          end else begin
            rsp.data = entries[pos - 1];
          end
        end
        OP_FIND: begin
          if (count == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.status = ST_NOTFOUND;
            for (int unsigned i = 0; i < count; i++) begin
              if (entries[i] == req.value) begin
                rsp.found_position = 5'(i + 1);
                rsp.status         = ST_OK;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      rsp.count = 5'(count);
      expected_q.push_back(rsp);
    endfunction

    // Counts a mismatch and reports only the first few in detail.
    function void flag(string what, plc_rsp_t exp, plc_rsp_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t MISMATCH %s: expected status=%0d data=%02h found=%0d count=%0d",
                 $realtime, what, exp.status, exp.data, exp.found_position, exp.count);
        $display("    got status=%0d data=%02h found=%0d count=%0d",
                 got.status, got.data, got.found_position, got.count);
      end
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_result(plc_rsp_t got);
      plc_rsp_t exp;
      if (expected_q.size() == 0) begin
        flag("result beat with no request pending", '0, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.data !== exp.data ||
          got.found_position !== exp.found_position || got.count !== exp.count) begin
        flag("result beat", exp, got);
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  plc_req_t req_i;
  logic     done_o;
  plc_rsp_t rsp_o;

  char_list_scoreboard sb;
  bit                  bursty;
  int unsigned         stall_cycles;

  positional_char_list #(
    .CAPACITY(Capacity)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result monitor: a result beat is valid only in the cycle done_o marks it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(rsp_o);
    end
  end

  // Watchdog: ends the run if neither a request nor a result moves for too long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Timeout: no handshake for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sends one request beat after a random gap (none in bursty phases) and waits until it is taken.
  task automatic send(input plc_req_t req);
    int unsigned gap;
    gap = bursty ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= req;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  task automatic send_op(input op_e op, input logic [4:0] position, input logic [7:0] value);
    plc_req_t req;
    req.op       = op;
    req.position = position;
    req.value    = value;
    send(req);
  endtask

  // Corner cases: empty list, insert into empty, range errors, full list,
  // tail delete, a find that hits only the last entry and the unused op codes.
  task automatic run_directed();
    send_op(OP_POP,    5'd0,  8'h00);
    send_op(OP_DELETE, 5'd1,  8'h00);
    send_op(OP_READ,   5'd0,  8'h00);
    send_op(OP_FIND,   5'd0,  8'h00);
    send_op(OP_INSERT, 5'd16, 8'hff);
    send_op(OP_INSERT, 5'd16, 8'h11);
    send_op(OP_INSERT, 5'd0,  8'h00);
    send_op(OP_READ,   5'd0,  8'h00);
    send_op(OP_READ,   5'd3,  8'h00);
    send_op(OP_FIND,   5'd0,  8'h5a);
    for (int unsigned i = 2; i < Capacity; i++) begin
      send_op(OP_APPEND, 5'd0, 8'(8'h80 + i));
    end
    send_op(OP_APPEND, 5'd0,  8'h55);
    send_op(OP_INSERT, 5'd1,  8'h55);
    send_op(OP_READ,   5'd16, 8'h00);
    send_op(OP_FIND,   5'd0,  8'h8f);
    send_op(OP_DELETE, 5'd16, 8'h00);
    send_op(OP_DELETE, 5'd16, 8'h00);
    send_op(OP_DELETE, 5'd1,  8'h00);
    send_op(op_e'(3'd6), 5'd31, 8'hff);
    send_op(op_e'(3'd7), 5'd0,  8'h00);
  endtask

  // Builds a random request; growing phases favor appends and inserts,
  // shrinking phases favor deletes and pops, so the count sweeps its range.
  function automatic plc_req_t random_request(bit growing);
    plc_req_t    req;
    int unsigned pick;
    int unsigned cnt;
    cnt  = sb.count;
    pick = $urandom_range(0, 99);
    if (growing) begin
      req.op = (pick < 30) ? OP_APPEND : (pick < 55) ? OP_INSERT : (pick < 65) ? OP_DELETE :
               (pick < 75) ? OP_POP : (pick < 85) ? OP_READ : OP_FIND;
    end else begin
      req.op = (pick < 10) ? OP_APPEND : (pick < 20) ? OP_INSERT : (pick < 50) ? OP_DELETE :
               (pick < 70) ? OP_POP : (pick < 85) ? OP_READ : OP_FIND;
    end
    if ($urandom_range(0, 3) != 0) begin
      req.position = 5'($urandom_range(0, cnt));
    end else begin
      req.position = 5'($urandom_range(0, Capacity));
    end
    if (req.op == OP_FIND && cnt > 0 && $urandom_range(0, 9) < 7) begin
      req.value = sb.entries[$urandom_range(0, cnt - 1)];
    end else begin
      req.value = 8'($urandom_range(0, 255));
    end
    return req;
  endfunction

  task automatic run_random();
    bit          growing;
    int unsigned phase_left;
    growing    = 1'b1;
    phase_left = 0;
    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (phase_left == 0) begin
        growing    = ~growing;
        phase_left = $urandom_range(20, 60);
        bursty     = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      send(random_request(growing));
    end
  endtask

  // Stimulus, drain and final verdict.
  initial begin
    int unsigned waited;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    bursty  = 1'b0;
    sb      = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();
    start_i <= 1'b0;

    // Let the last result beats come back, then wait quietly before the verdict.
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);

    if (sb.expected_q.size() != 0) begin
      $display("%0d expected result beats never arrived", sb.expected_q.size());
    end
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
